@@ sv/alm_pkg.sv @@
package alm_pkg;

    localparam int LEVEL_W    = 16;
    localparam int COEF_W     = 16;
    localparam int DECAY_W    = 15;
    localparam int CNT_W      = 8;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Q1.15 coefficients: product is shifted down by this much
    localparam int COEF_FRAC  = 15;

    localparam logic [COEF_W-1:0]  ATTACK_COEF_RST     = 16'd19661;
    localparam logic [COEF_W-1:0]  RELEASE_COEF_RST    = 16'd6554;
    localparam logic [DECAY_W-1:0] DECAY_STEP_RST      = 15'd328;
    localparam logic [LEVEL_W-1:0] CLIP_THRESHOLD_RST  = 16'd16384;
    localparam logic [CNT_W-1:0]   CLIP_HOLD_TICKS_RST = 8'd30;

    typedef enum logic [0:0] {
        CMD_LEVEL = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ATTACK_COEF     = 3'd0,
        REG_RELEASE_COEF    = 3'd1,
        REG_DECAY_STEP      = 3'd2,
        REG_CLIP_THRESHOLD  = 3'd3,
        REG_CLIP_HOLD_TICKS = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0]  attack_coef;
        logic [COEF_W-1:0]  release_coef;
        logic [DECAY_W-1:0] decay_step;
        logic [LEVEL_W-1:0] clip_threshold;
        logic [CNT_W-1:0]   clip_hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] smooth;
        logic [LEVEL_W-1:0] hold;
        logic [CNT_W-1:0]   clip_count;
        logic               clip_flag;
    } meter_state_t;

endpackage

@@ sv/alm_if.sv @@
interface alm_item_if;
    logic                           valid;
    logic                           ready;
    alm_pkg::cmd_t                  command;
    logic [alm_pkg::LEVEL_W-1:0]    level;

    modport source (output valid, output command, output level, input ready);
    modport sink   (input valid, input command, input level, output ready);
endinterface

interface alm_result_if;
    logic                           valid;
    logic                           ready;
    logic [alm_pkg::LEVEL_W-1:0]    smoothed_level;
    logic [alm_pkg::LEVEL_W-1:0]    held_peak;
    logic                           clip_on;

    modport source (output valid, output smoothed_level, output held_peak, output clip_on,
                    input ready);
    modport sink   (input valid, input smoothed_level, input held_peak, input clip_on,
                    output ready);
endinterface

interface alm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [alm_pkg::REG_IDX_W-1:0]      index;
    logic [alm_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/alm_update.sv @@
// Next meter state for one request: attack/release smoothing, peak hold, clip.
module alm_update (
    input  alm_pkg::cfg_t                cfg,
    input  alm_pkg::meter_state_t        state,
    input  alm_pkg::cmd_t                command,
    input  logic [alm_pkg::LEVEL_W-1:0]  level,
    output alm_pkg::meter_state_t        state_next
);

    localparam int DIFF_W = alm_pkg::LEVEL_W + 1;
    localparam int PROD_W = DIFF_W + alm_pkg::COEF_W + 1;
    localparam int SUM_W  = PROD_W - alm_pkg::COEF_FRAC + 1;

    logic                            rising;
    logic signed [DIFF_W-1:0]        diff;
    logic [alm_pkg::COEF_W-1:0]      coef;
    logic signed [PROD_W-1:0]        prod;
    logic signed [PROD_W-1:0]        step;
    logic signed [SUM_W-1:0]         sum;
    logic [alm_pkg::LEVEL_W-1:0]     smooth_sat;
    logic [alm_pkg::LEVEL_W-1:0]     hold_dec;
    logic [alm_pkg::DECAY_W-1:0]     decay;

    assign rising = level > state.smooth;
    assign diff   = $signed({1'b0, level}) - $signed({1'b0, state.smooth});
    assign coef   = rising ? cfg.attack_coef : cfg.release_coef;
    assign prod   = PROD_W'(diff) * PROD_W'($signed({1'b0, coef}));
    // arithmetic shift floors toward minus infinity
    assign step   = prod >>> alm_pkg::COEF_FRAC;
    assign sum    = SUM_W'($signed({1'b0, state.smooth})) + SUM_W'(step);

    always_comb
    begin
        if (sum[SUM_W-1])
        begin
            smooth_sat = '0;
        end
        else if (sum > $signed(SUM_W'({alm_pkg::LEVEL_W{1'b1}})))
        begin
            smooth_sat = '1;
        end
        else
        begin
            smooth_sat = sum[alm_pkg::LEVEL_W-1:0];
        end
    end

    assign decay    = cfg.decay_step;
    assign hold_dec = (state.hold > alm_pkg::LEVEL_W'(decay))
                    ? state.hold - alm_pkg::LEVEL_W'(decay) : '0;

    always_comb
    begin
        state_next = state;
        case (command)
            alm_pkg::CMD_LEVEL:
            begin
                state_next.smooth = smooth_sat;
                if (level >= state.hold)
                begin
                    state_next.hold = level;
                end
                if (level >= cfg.clip_threshold)
                begin
                    state_next.clip_flag  = 1'b1;
                    state_next.clip_count = cfg.clip_hold_ticks;
                end
            end
            default:
            begin
                state_next.hold = hold_dec;
                if (state.clip_count != '0)
                begin
                    state_next.clip_count = state.clip_count - alm_pkg::CNT_W'(1);
                    if (state.clip_count == alm_pkg::CNT_W'(1))
                    begin
                        state_next.clip_flag = 1'b0;
                    end
                end
            end
        endcase
    end

endmodule

@@ sv/audio_level_meter_ballistics.sv @@
// Level meter ballistics. Each request on "item" is either a level sample
// (command 0), which pulls the smoothed level toward the sample by a Q1.15
// attack or release fraction of the difference (floored, saturated to
// 0..65535), raises the peak hold and may flag clipping, or a decay tick
// (command 1), which lowers the peak hold by decay_step and counts the clip
// indication down. Every request yields exactly one request on "result" with
// the meter state after it. Throughput is one request per clock while results
// are taken; a request passes the input register, then the state/result
// register, before its result is offered. The clock period is set by the
// state feedback loop: a 17x17 signed multiply, an add and saturation
// between the state register and itself. Registers on "cfg" (0 attack,
// 1 release, 2 decay step, 3 clip threshold, 4 clip hold ticks) take effect
// for requests processed after the write; other indexes are ignored. Write
// them only while idle.
module audio_level_meter_ballistics (
    input  logic           clk,
    input  logic           rst_n,
    alm_item_if.sink       item,
    alm_result_if.source   result,
    alm_cfg_if.sink        cfg
);

    // configuration registers
    alm_pkg::cfg_t                  cfg_reg;

    // input stage
    logic                           s1_valid_reg;
    alm_pkg::cmd_t                  s1_cmd_reg;
    logic [alm_pkg::LEVEL_W-1:0]    s1_level_reg;
    logic                           s1_adv;

    // meter state doubles as the result register
    alm_pkg::meter_state_t          state_reg;
    alm_pkg::meter_state_t          state_next;
    logic                           out_valid_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_coef     <= alm_pkg::ATTACK_COEF_RST;
            cfg_reg.release_coef    <= alm_pkg::RELEASE_COEF_RST;
            cfg_reg.decay_step      <= alm_pkg::DECAY_STEP_RST;
            cfg_reg.clip_threshold  <= alm_pkg::CLIP_THRESHOLD_RST;
            cfg_reg.clip_hold_ticks <= alm_pkg::CLIP_HOLD_TICKS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (alm_pkg::reg_idx_t'(cfg.index))
                alm_pkg::REG_ATTACK_COEF:
                    cfg_reg.attack_coef <= cfg.data;
                alm_pkg::REG_RELEASE_COEF:
                    cfg_reg.release_coef <= cfg.data;
                alm_pkg::REG_DECAY_STEP:
                    cfg_reg.decay_step <= cfg.data[alm_pkg::DECAY_W-1:0];
                alm_pkg::REG_CLIP_THRESHOLD:
                    cfg_reg.clip_threshold <= cfg.data;
                alm_pkg::REG_CLIP_HOLD_TICKS:
                    cfg_reg.clip_hold_ticks <= cfg.data[alm_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Stage 1 moves on when the result slot is empty or being drained.
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_cmd_reg   <= item.command;
            s1_level_reg <= item.level;
        end
    end

    alm_update u_update (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .command    (s1_cmd_reg),
        .level      (s1_level_reg),
        .state_next (state_next)
    );

    // State only changes when a result is produced, so it is the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.smoothed_level = state_reg.smooth;
    assign result.held_peak      = state_reg.hold;
    assign result.clip_on        = state_reg.clip_flag;

    // a running clip countdown always shows the flag
    a_count_implies_flag: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.clip_count != '0 |-> state_reg.clip_flag)
        else $error("clip count running with flag clear");

    // a level sample leaves the hold at or above that sample
    a_hold_covers_level: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_cmd_reg == alm_pkg::CMD_LEVEL)
        |=> state_reg.hold >= $past(s1_level_reg))
        else $error("peak hold below level sample");

    // a tick never raises the hold or the smoothed level changes
    a_tick_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_cmd_reg == alm_pkg::CMD_TICK)
        |=> (state_reg.hold <= $past(state_reg.hold))
            && (state_reg.smooth == $past(state_reg.smooth)))
        else $error("tick raised hold or moved smoothed level");

    // state is frozen while a result waits
    a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> $stable(state_reg))
        else $error("state changed under a stalled result");

    // accepted request is captured into stage 1
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> s1_valid_reg)
        else $error("accepted request lost");

endmodule

@@ dv/tb_audio_level_meter_ballistics.sv @@
module tb_audio_level_meter_ballistics;

    import alm_pkg::*;

    // Spare register indexes: writes there must leave the meter settings alone
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int NUM_PHASES      = 7;
    localparam int RANDOM_PER_PHASE = 205;
    localparam int MAX_PRINTED     = 40;

    // One request on the item channel
    typedef struct {
        cmd_t               cmd;
        logic [LEVEL_W-1:0] lvl;
    } meter_req_t;

    // What the meter should show after a request
    typedef struct {
        logic [LEVEL_W-1:0] smoothed;
        logic [LEVEL_W-1:0] peak;
        logic               clip;
    } meter_reading_t;

    logic clk = 1'b0;
    logic rst_n;

    alm_item_if   item_bus ();
    alm_result_if result_bus ();
    alm_cfg_if    cfg_bus ();

    audio_level_meter_ballistics dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pending requests for the driver, readings still owed by the block
    meter_req_t     pending_reqs[$];
    meter_reading_t expected_readings[$];

    // Our own copy of the settings and of the meter state
    cfg_t         meter_cfg;
    meter_state_t meter;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   reqs_queued   = 0;
    int   reqs_accepted = 0;
    int   mismatches    = 0;
    logic item_fire     = 1'b0;

    task automatic note_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Register write as the block stores it: truncated to the field width,
    // unknown indexes dropped
    function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_ATTACK_COEF:     meter_cfg.attack_coef     = val;
            REG_RELEASE_COEF:    meter_cfg.release_coef    = val;
            REG_DECAY_STEP:      meter_cfg.decay_step      = val[DECAY_W-1:0];
            REG_CLIP_THRESHOLD:  meter_cfg.clip_threshold  = val;
            REG_CLIP_HOLD_TICKS: meter_cfg.clip_hold_ticks = val[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Ballistics for one request
    function automatic meter_state_t meter_step(input meter_state_t s, input cmd_t cmd,
                                                input logic [LEVEL_W-1:0] lvl);
        longint gap;
        longint gain;
        longint nxt;
        meter_state_t n;
        n = s;
        if (cmd == CMD_LEVEL)
        begin
            // Signed gap times Q1.15 gain, floored by an arithmetic shift
            gap  = longint'(lvl) - longint'(s.smooth);
            gain = (lvl > s.smooth) ? longint'(meter_cfg.attack_coef)
                                    : longint'(meter_cfg.release_coef);
            nxt  = longint'(s.smooth) + ((gain * gap) >>> COEF_FRAC);
            // Gains above one can overshoot either way
            if (nxt < 0)
                nxt = 0;
            if (nxt > 65535)
                nxt = 65535;
            n.smooth = nxt[LEVEL_W-1:0];
            if (lvl >= s.hold)
                n.hold = lvl;
            if (lvl >= meter_cfg.clip_threshold)
            begin
                n.clip_flag  = 1'b1;
                n.clip_count = meter_cfg.clip_hold_ticks;
            end
        end
        else
        begin
            if (s.hold != '0)
                n.hold = (s.hold > LEVEL_W'(meter_cfg.decay_step))
                         ? s.hold - LEVEL_W'(meter_cfg.decay_step) : '0;
            // A count of zero never clears the flag
            if (s.clip_count != '0)
            begin
                n.clip_count = s.clip_count - 1'b1;
                if (n.clip_count == '0)
                    n.clip_flag = 1'b0;
            end
        end
        return n;
    endfunction

    task automatic queue_req(input cmd_t cmd, input logic [LEVEL_W-1:0] lvl);
        meter_req_t r;
        r.cmd = cmd;
        r.lvl = lvl;
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    // Random mix: level samples shaped around the threshold and the extremes,
    // single ticks, and long runs of ticks so hold decay and clip timeout play out
    task automatic queue_random(input int n);
        int left;
        int burst;
        int t;
        logic [LEVEL_W-1:0] lvl;
        logic [LEVEL_W-1:0] last_lvl;
        left = n;
        last_lvl = '0;
        while (left > 0)
        begin
            if ($urandom_range(99) < 8)
            begin
                burst = $urandom_range(40, 5);
                repeat (burst) queue_req(CMD_TICK, LEVEL_W'($urandom));
                left -= burst;
            end
            else if ($urandom_range(99) < 35)
            begin
                // level field is don't-care on a tick; toggle it anyway
                queue_req(CMD_TICK, LEVEL_W'($urandom));
                left--;
            end
            else
            begin
                case ($urandom_range(9))
                    0, 1, 2: lvl = LEVEL_W'($urandom);
                    3, 4, 5: lvl = LEVEL_W'($urandom_range(meter_cfg.clip_threshold));
                    6:
                    begin
                        t = int'(meter_cfg.clip_threshold) + int'($urandom_range(4)) - 2;
                        if (t < 0)
                            t = 0;
                        if (t > 65535)
                            t = 65535;
                        lvl = LEVEL_W'(t);
                    end
                    7: lvl = ($urandom_range(1) != 0) ? '1 : '0;
                    8: lvl = last_lvl;
                    default: lvl = LEVEL_W'($urandom_range(255));
                endcase
                last_lvl = lvl;
                queue_req(CMD_LEVEL, lvl);
                left--;
            end
        end
    endtask

    // Config write: hold valid until the block takes it, then update our copy
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Driver: new request only once the previous one was taken; inputs
    // change on the falling edge, away from the sampling edge
    always @(negedge clk)
    begin
        meter_req_t req;
        if (!rst_n)
        begin
            item_bus.valid   <= 1'b0;
            result_bus.ready <= 1'b0;
        end
        else
        begin
            if (!item_bus.valid || item_fire)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req = pending_reqs.pop_front();
                    item_bus.valid   <= 1'b1;
                    item_bus.command <= req.cmd;
                    item_bus.level   <= req.lvl;
                end
                else
                    item_bus.valid <= 1'b0;
            end
            result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on each accepted request, check each accepted result
    // against the oldest reading still owed
    always @(posedge clk)
    begin
        meter_reading_t exp_rd;
        if (!rst_n)
            item_fire <= 1'b0;
        else
        begin
            item_fire <= item_bus.valid && item_bus.ready;
            if (item_bus.valid && item_bus.ready)
            begin
                meter = meter_step(meter, item_bus.command, item_bus.level);
                exp_rd.smoothed = meter.smooth;
                exp_rd.peak     = meter.hold;
                exp_rd.clip     = meter.clip_flag;
                expected_readings.push_back(exp_rd);
                reqs_accepted++;
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_readings.size() == 0)
                    note_mismatch($sformatf("unexpected result: smoothed %0d peak %0d clip %0b",
                        result_bus.smoothed_level, result_bus.held_peak, result_bus.clip_on));
                else
                begin
                    exp_rd = expected_readings.pop_front();
                    if (result_bus.smoothed_level !== exp_rd.smoothed)
                        note_mismatch($sformatf("smoothed_level %0d, expected %0d",
                            result_bus.smoothed_level, exp_rd.smoothed));
                    if (result_bus.held_peak !== exp_rd.peak)
                        note_mismatch($sformatf("held_peak %0d, expected %0d",
                            result_bus.held_peak, exp_rd.peak));
                    if (result_bus.clip_on !== exp_rd.clip)
                        note_mismatch($sformatf("clip_on %0b, expected %0b",
                            result_bus.clip_on, exp_rd.clip));
                end
            end
        end
    end

    // Main sequence: reset, then phases of (settings, requests, drain)
    initial
    begin
        rst_n            = 1'b0;
        item_bus.valid   = 1'b0;
        item_bus.command = CMD_LEVEL;
        item_bus.level   = '0;
        result_bus.ready = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = REG_ATTACK_COEF;
        cfg_bus.data     = '0;

        meter_cfg.attack_coef     = ATTACK_COEF_RST;
        meter_cfg.release_coef    = RELEASE_COEF_RST;
        meter_cfg.decay_step      = DECAY_STEP_RST;
        meter_cfg.clip_threshold  = CLIP_THRESHOLD_RST;
        meter_cfg.clip_hold_ticks = CLIP_HOLD_TICKS_RST;
        meter = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // Back-pressure mix: receiver-heavy idling, then sender-heavy, then none
            if (phase < 3)
            begin
                send_idle_pct = 30;
                recv_idle_pct = 49;
            end
            else if (phase < 5)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (phase)
                0:
                begin
                    // Reset settings: edges of threshold, full scale, both
                    // directions of smoothing, hold ties, alternating bits
                    queue_req(CMD_LEVEL, 16'd0);
                    queue_req(CMD_TICK,  16'hFFFF);
                    queue_req(CMD_LEVEL, 16'd16383);
                    queue_req(CMD_LEVEL, 16'd16384);
                    queue_req(CMD_LEVEL, 16'hFFFF);
                    queue_req(CMD_LEVEL, 16'hFFFF);
                    queue_req(CMD_TICK,  16'd0);
                    queue_req(CMD_LEVEL, 16'd0);
                    queue_req(CMD_LEVEL, 16'h5555);
                    queue_req(CMD_LEVEL, 16'hAAAA);
                    queue_req(CMD_LEVEL, 16'd1);
                    queue_req(CMD_LEVEL, 16'd16385);
                    queue_req(CMD_TICK,  16'h5555);
                    queue_req(CMD_TICK,  16'hAAAA);
                    queue_req(CMD_TICK,  16'd0);
                    queue_req(CMD_LEVEL, 16'd32768);
                    queue_req(CMD_LEVEL, 16'd0);
                    queue_req(CMD_TICK,  16'd0);
                end
                1:
                begin
                    // Unity gain, a decay step of 16384, clip only at full scale,
                    // longest clip hold; spare indexes must be ignored
                    write_reg(REG_ATTACK_COEF,     16'd32768);
                    write_reg(REG_RELEASE_COEF,    16'd32768);
                    write_reg(REG_DECAY_STEP,      16'd16384);
                    write_reg(REG_CLIP_THRESHOLD,  16'hFFFF);
                    write_reg(REG_CLIP_HOLD_TICKS, 16'd255);
                    write_reg(REG_SPARE_LO,        16'h1234);
                    write_reg(REG_SPARE_HI,        16'hFFFF);
                end
                2:
                begin
                    // Frozen smoothing, no decay, every sample clips and the
                    // flag sticks since the hold count is zero
                    write_reg(REG_ATTACK_COEF,     16'd0);
                    write_reg(REG_RELEASE_COEF,    16'd0);
                    write_reg(REG_DECAY_STEP,      16'd0);
                    write_reg(REG_CLIP_THRESHOLD,  16'd0);
                    write_reg(REG_CLIP_HOLD_TICKS, 16'd0);
                end
                3:
                begin
                    // Gains near two overshoot; oversized decay and hold
                    // values keep only their low bits
                    write_reg(REG_ATTACK_COEF,     16'hFFFF);
                    write_reg(REG_RELEASE_COEF,    16'hFFFF);
                    write_reg(REG_DECAY_STEP,      16'hFFFF);
                    write_reg(REG_CLIP_THRESHOLD,  16'd20000);
                    write_reg(REG_CLIP_HOLD_TICKS, 16'h0103);
                end
                4:
                begin
                    write_reg(REG_ATTACK_COEF,     CFG_DATA_W'($urandom_range(32768)));
                    write_reg(REG_RELEASE_COEF,    CFG_DATA_W'($urandom));
                    write_reg(REG_DECAY_STEP,      CFG_DATA_W'($urandom));
                    write_reg(REG_CLIP_THRESHOLD,  CFG_DATA_W'($urandom));
                    write_reg(REG_CLIP_HOLD_TICKS, CFG_DATA_W'($urandom_range(255)));
                end
                5:
                begin
                    // Short clip holds so the flag toggles often
                    write_reg(REG_ATTACK_COEF,     CFG_DATA_W'($urandom));
                    write_reg(REG_RELEASE_COEF,    CFG_DATA_W'($urandom_range(32768)));
                    write_reg(REG_DECAY_STEP,      CFG_DATA_W'($urandom_range(2000)));
                    write_reg(REG_CLIP_THRESHOLD,  CFG_DATA_W'($urandom_range(40000, 8192)));
                    write_reg(REG_CLIP_HOLD_TICKS, CFG_DATA_W'($urandom_range(8)));
                end
                default:
                begin
                    write_reg(REG_ATTACK_COEF,     CFG_DATA_W'(ATTACK_COEF_RST));
                    write_reg(REG_RELEASE_COEF,    CFG_DATA_W'(RELEASE_COEF_RST));
                    write_reg(REG_DECAY_STEP,      CFG_DATA_W'(DECAY_STEP_RST));
                    write_reg(REG_CLIP_THRESHOLD,  CFG_DATA_W'(CLIP_THRESHOLD_RST));
                    write_reg(REG_CLIP_HOLD_TICKS, CFG_DATA_W'(CLIP_HOLD_TICKS_RST));
                end
            endcase

            if (phase > 0)
                queue_random(RANDOM_PER_PHASE);

            // Drain: every request taken and every reading delivered, then let
            // the pipeline settle before settings change again
            while (reqs_accepted != reqs_queued || expected_readings.size() != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end

        if (mismatches == 0)
            $display("PASS audio_level_meter_ballistics");
        else
            $display("FAIL audio_level_meter_ballistics");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("FAIL audio_level_meter_ballistics");
        $finish;
    end

endmodule
